FILE: hdl/mhtq_pkg.sv
// Package of the min-heap timer queue: operation and status codes and
// the fixed field widths of the stream ports. No dependencies.
`timescale 1ns / 1ps
package mhtq_pkg;

  localparam int OP_W     = 2;
  localparam int ID_W     = 16;
  localparam int TIME_W   = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 6;

  typedef enum logic [OP_W-1:0] {
    OP_ADD    = 2'd0,
    OP_CANCEL = 2'd1,
    OP_ADJUST = 2'd2,
    OP_TICK   = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE      = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_EXPIRED   = 2'd3
  } status_t;

endpackage

FILE: hdl/mhtq_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Used by the heap store of the timer queue; no package dependencies.
`timescale 1ns / 1ps
module mhtq_ram #(
  parameter int WIDTH = 49,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

FILE: hdl/min_heap_timer_queue_unit.sv
// Top level of the min-heap timer queue: sequencer, heap walk and stream ports.
// Depends on mhtq_pkg and on the heap store mhtq_ram.
//
//  Channel | Dir | Ports                               | Contents
//  --------+-----+-------------------------------------+------------------------------------
//  in      | in  | in_tvalid/in_tready/in_tdata/tuser  | tuser: operation; tdata: id, times
//  out     | out | out_tvalid/out_tready/out_tdata/... | tuser: status; tdata: id, count
//
// One input transfer is taken only while the sequencer is idle. Add sifts
// the new entry up towards the root; cancel and adjust first scan the
// entries one by one from the root. Tick reads and tests the top, and for
// every popped entry fetches the last entry and sifts it down, with one
// emit step per result. Every step goes through the single read port of
// the heap RAM, which sets the pace.
// Reset clears the sequencer, the entry count and the output valid bit; the
// RAM contents are never cleared, as only the first count entries are read.
// A stalled result transfer holds the sequencer at its next emit.
`timescale 1ns / 1ps
module min_heap_timer_queue_unit
  import mhtq_pkg::*;
#(
  parameter int CAPACITY  = 32,
  parameter int ID_BITS   = 16,
  parameter int TIME_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [79:0] in_tdata,   // [15:0] timer_id, [47:16] expire_time, [79:48] now_time
  input  logic [1:0]  in_tuser,   // [1:0] operation
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [15:0] fired_id, [21:16] entry_count, [23:22] zero
  output logic [1:0]  out_tuser,  // [1:0] status
  output logic        out_tlast   // last result of the input
);

  localparam int IW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int WW = 1 + ID_BITS + TIME_BITS;

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN_RD, S_SCAN_CHK, S_UP, S_UP_CHK, S_DN, S_DN_L, S_DN_R,
    S_DN_CMP, S_TK_RD, S_TK_CHK, S_POP_RD, S_POP_LD, S_EMIT
  } state_t;

  // Input fields narrowed or widened to the internal widths.
  logic [31:0]          id_ext;
  logic [63:0]          exp_ext, now_ext;
  logic [ID_BITS-1:0]   in_id;
  logic [TIME_BITS-1:0] in_exp, in_now;
  assign id_ext  = {16'd0, in_tdata[15:0]};
  assign exp_ext = {32'd0, in_tdata[47:16]};
  assign now_ext = {32'd0, in_tdata[79:48]};
  assign in_id   = id_ext[ID_BITS-1:0];
  assign in_exp  = exp_ext[TIME_BITS-1:0];
  assign in_now  = now_ext[TIME_BITS-1:0];

  state_t               state_r, state_nxt, em_next_r, em_next_nxt;
  op_t                  op_r, op_nxt;
  logic [ID_BITS-1:0]   id_r, id_nxt;
  logic [TIME_BITS-1:0] key_r, key_nxt, now_r, now_nxt;
  logic [CW-1:0]        cnt_r, cnt_nxt, pos_r, pos_nxt, cidx_r, cidx_nxt;
  // Moving entry (x) and chosen child (c) of a sift.
  logic [TIME_BITS-1:0] x_key_r, x_key_nxt, c_key_r, c_key_nxt;
  logic [ID_BITS-1:0]   x_id_r, x_id_nxt, c_id_r, c_id_nxt;
  logic                 x_can_r, x_can_nxt, c_can_r, c_can_nxt;
  // A fired timer is held back until it is known whether it is the last one.
  logic                 pend_v_r, pend_v_nxt;
  logic [ID_BITS-1:0]   pend_id_r, pend_id_nxt;
  logic [CW-1:0]        pend_cnt_r, pend_cnt_nxt;
  // Result waiting to enter the output register.
  status_t              em_st_r, em_st_nxt;
  logic [ID_BITS-1:0]   em_id_r, em_id_nxt;
  logic [CW-1:0]        em_cnt_r, em_cnt_nxt;
  logic                 em_last_r, em_last_nxt;
  // Output register.
  logic                 ov_r, ov_nxt, olast_r, olast_nxt;
  status_t              ost_r, ost_nxt;
  logic [15:0]          oid_r, oid_nxt;
  logic [COUNT_W-1:0]   ocnt_r, ocnt_nxt;

  // Heap RAM ports.
  logic                 wr_en;
  logic [IW-1:0]        wr_addr, rd_addr;
  logic [WW-1:0]        wr_data, rd_data;
  logic [TIME_BITS-1:0] d_key;
  logic [ID_BITS-1:0]   d_id;
  logic                 d_can;
  assign d_key = rd_data[TIME_BITS-1:0];
  assign d_id  = rd_data[TIME_BITS+ID_BITS-1:TIME_BITS];
  assign d_can = rd_data[WW-1];

  mhtq_ram #(.WIDTH(WW), .DEPTH(CAPACITY)) u_heap (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  logic [CW:0]   left_w, right_w, cnt_w;
  logic [CW-1:0] parent_w, cnt_m1;
  logic [31:0]   oid_ext;
  assign left_w   = {pos_r, 1'b1};
  assign right_w  = left_w + 1'b1;
  assign cnt_w    = {1'b0, cnt_r};
  assign parent_w = (pos_r - 1'b1) >> 1;
  assign cnt_m1   = cnt_r - 1'b1;
  assign oid_ext  = 32'(em_id_r);

  always_comb begin
    state_nxt    = state_r;
    em_next_nxt  = em_next_r;
    op_nxt       = op_r;
    id_nxt       = id_r;
    key_nxt      = key_r;
    now_nxt      = now_r;
    cnt_nxt      = cnt_r;
    pos_nxt      = pos_r;
    cidx_nxt     = cidx_r;
    x_key_nxt    = x_key_r;
    x_id_nxt     = x_id_r;
    x_can_nxt    = x_can_r;
    c_key_nxt    = c_key_r;
    c_id_nxt     = c_id_r;
    c_can_nxt    = c_can_r;
    pend_v_nxt   = pend_v_r;
    pend_id_nxt  = pend_id_r;
    pend_cnt_nxt = pend_cnt_r;
    em_st_nxt    = em_st_r;
    em_id_nxt    = em_id_r;
    em_cnt_nxt   = em_cnt_r;
    em_last_nxt  = em_last_r;
    ov_nxt       = ov_r && !out_tready;
    ost_nxt      = ost_r;
    oid_nxt      = oid_r;
    ocnt_nxt     = ocnt_r;
    olast_nxt    = olast_r;
    wr_en        = 1'b0;
    wr_addr      = pos_r[IW-1:0];
    wr_data      = {x_can_r, x_id_r, x_key_r};
    rd_addr      = pos_r[IW-1:0];

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          op_nxt  = op_t'(in_tuser);
          id_nxt  = in_id;
          key_nxt = in_exp;
          now_nxt = in_now;
          case (op_t'(in_tuser))
            OP_ADD: begin
              em_next_nxt = S_IDLE;
              em_last_nxt = 1'b1;
              em_id_nxt   = '0;
              em_cnt_nxt  = cnt_r;
              if (cnt_w >= (CW+1)'(CAPACITY)) begin
                em_st_nxt = ST_FULL;
                state_nxt = S_EMIT;
              end else begin
                x_key_nxt = in_exp;
                x_id_nxt  = in_id;
                x_can_nxt = 1'b0;
                pos_nxt   = cnt_r;
                cnt_nxt   = cnt_r + 1'b1;
                state_nxt = S_UP;
              end
            end
            OP_CANCEL, OP_ADJUST: begin
              pos_nxt   = '0;
              state_nxt = S_SCAN_RD;
            end
            default: begin
              pend_v_nxt = 1'b0;
              state_nxt  = S_TK_RD;
            end
          endcase
        end
      end
      S_SCAN_RD: begin
        em_next_nxt = S_IDLE;
        em_last_nxt = 1'b1;
        em_id_nxt   = '0;
        em_cnt_nxt  = cnt_r;
        if (pos_r >= cnt_r) begin
          if (op_r == OP_CANCEL) begin
            em_st_nxt = ST_NOT_FOUND;
            state_nxt = S_EMIT;
          end else if (cnt_w >= (CW+1)'(CAPACITY)) begin
            em_st_nxt = ST_FULL;
            state_nxt = S_EMIT;
          end else begin
            x_key_nxt = key_r;
            x_id_nxt  = id_r;
            x_can_nxt = 1'b0;
            pos_nxt   = cnt_r;
            cnt_nxt   = cnt_r + 1'b1;
            state_nxt = S_UP;
          end
        end else begin
          state_nxt = S_SCAN_CHK;
        end
      end
      S_SCAN_CHK: begin
        em_st_nxt = ST_DONE;
        if (d_id == id_r) begin
          if (op_r == OP_CANCEL) begin
            wr_en     = 1'b1;
            wr_data   = {1'b1, d_id, d_key};
            state_nxt = S_EMIT;
          end else if (key_r == d_key) begin
            state_nxt = S_EMIT;
          end else begin
            x_key_nxt = key_r;
            x_id_nxt  = d_id;
            x_can_nxt = d_can;
            state_nxt = (key_r < d_key) ? S_UP : S_DN;
          end
        end else begin
          pos_nxt   = pos_r + 1'b1;
          state_nxt = S_SCAN_RD;
        end
      end
      S_UP: begin
        if (pos_r == '0) begin
          wr_en = 1'b1;
          state_nxt  = (op_r == OP_TICK) ? S_TK_RD : S_EMIT;
          em_st_nxt  = ST_DONE;
          em_cnt_nxt = cnt_r;
        end else begin
          rd_addr   = parent_w[IW-1:0];
          state_nxt = S_UP_CHK;
        end
      end
      S_UP_CHK: begin
        wr_en = 1'b1;
        if (d_key <= x_key_r) begin
          state_nxt  = S_EMIT;
          em_st_nxt  = ST_DONE;
          em_cnt_nxt = cnt_r;
        end else begin
          wr_data   = rd_data;
          pos_nxt   = parent_w;
          state_nxt = S_UP;
        end
      end
      S_DN: begin
        if (left_w >= cnt_w) begin
          wr_en      = 1'b1;
          state_nxt  = (op_r == OP_TICK) ? S_TK_RD : S_EMIT;
          em_st_nxt  = ST_DONE;
          em_cnt_nxt = cnt_r;
        end else begin
          rd_addr   = left_w[IW-1:0];
          state_nxt = S_DN_L;
        end
      end
      S_DN_L: begin
        c_key_nxt = d_key;
        c_id_nxt  = d_id;
        c_can_nxt = d_can;
        cidx_nxt  = left_w[CW-1:0];
        if (right_w < cnt_w) begin
          rd_addr   = right_w[IW-1:0];
          state_nxt = S_DN_R;
        end else begin
          state_nxt = S_DN_CMP;
        end
      end
      S_DN_R: begin
        // The right child wins only on a strictly smaller key.
        if (d_key < c_key_r) begin
          c_key_nxt = d_key;
          c_id_nxt  = d_id;
          c_can_nxt = d_can;
          cidx_nxt  = right_w[CW-1:0];
        end
        state_nxt = S_DN_CMP;
      end
      S_DN_CMP: begin
        wr_en = 1'b1;
        if (!(c_key_r < x_key_r)) begin
          state_nxt  = (op_r == OP_TICK) ? S_TK_RD : S_EMIT;
          em_st_nxt  = ST_DONE;
          em_cnt_nxt = cnt_r;
        end else begin
          wr_data   = {c_can_r, c_id_r, c_key_r};
          pos_nxt   = cidx_r;
          state_nxt = S_DN;
        end
      end
      S_TK_RD: begin
        rd_addr     = '0;
        em_next_nxt = S_IDLE;
        em_last_nxt = 1'b1;
        em_cnt_nxt  = cnt_r;
        if (cnt_r == '0 ) begin
          em_st_nxt  = pend_v_r ? ST_EXPIRED : ST_DONE;
          em_id_nxt  = pend_v_r ? pend_id_r : '0;
          pend_v_nxt = 1'b0;
          state_nxt  = S_EMIT;
        end else begin
          state_nxt = S_TK_CHK;
        end
      end
      S_TK_CHK: begin
        if (!d_can && d_key > now_r) begin
          em_next_nxt = S_IDLE;
          em_last_nxt = 1'b1;
          em_cnt_nxt  = cnt_r;
          em_st_nxt   = pend_v_r ? ST_EXPIRED : ST_DONE;
          em_id_nxt   = pend_v_r ? pend_id_r : '0;
          pend_v_nxt  = 1'b0;
          state_nxt   = S_EMIT;
        end else begin
          // Pop the top; a live top also fires.
          cnt_nxt   = cnt_m1;
          pos_nxt   = '0;
          state_nxt = (cnt_m1 != '0) ? S_POP_RD : S_TK_RD;
          if (!d_can) begin
            pend_v_nxt   = 1'b1;
            pend_id_nxt  = d_id;
            pend_cnt_nxt = cnt_m1;
            if (pend_v_r) begin
              em_st_nxt   = ST_EXPIRED;
              em_id_nxt   = pend_id_r;
              em_cnt_nxt  = pend_cnt_r;
              em_last_nxt = 1'b0;
              em_next_nxt = (cnt_m1 != '0) ? S_POP_RD : S_TK_RD;
              state_nxt   = S_EMIT;
            end
          end
        end
      end
      S_POP_RD: begin
        rd_addr   = cnt_r[IW-1:0];
        state_nxt = S_POP_LD;
      end
      S_POP_LD: begin
        x_key_nxt = d_key;
        x_id_nxt  = d_id;
        x_can_nxt = d_can;
        state_nxt = S_DN;
      end
      S_EMIT: begin
        if (!ov_r || out_tready) begin
          ov_nxt    = 1'b1;
          ost_nxt   = em_st_r;
          oid_nxt   = oid_ext[15:0];
          ocnt_nxt  = COUNT_W'(em_cnt_r);
          olast_nxt = em_last_r;
          state_nxt = em_next_r;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      em_next_r <= S_IDLE;
      cnt_r     <= '0;
      pend_v_r  <= 1'b0;
      ov_r      <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      em_next_r <= em_next_nxt;
      cnt_r     <= cnt_nxt;
      pend_v_r  <= pend_v_nxt;
      ov_r      <= ov_nxt;
    end
    op_r       <= op_nxt;
    id_r       <= id_nxt;
    key_r      <= key_nxt;
    now_r      <= now_nxt;
    pos_r      <= pos_nxt;
    cidx_r     <= cidx_nxt;
    x_key_r    <= x_key_nxt;
    x_id_r     <= x_id_nxt;
    x_can_r    <= x_can_nxt;
    c_key_r    <= c_key_nxt;
    c_id_r     <= c_id_nxt;
    c_can_r    <= c_can_nxt;
    pend_id_r  <= pend_id_nxt;
    pend_cnt_r <= pend_cnt_nxt;
    em_st_r    <= em_st_nxt;
    em_id_r    <= em_id_nxt;
    em_cnt_r   <= em_cnt_nxt;
    em_last_r  <= em_last_nxt;
    ost_r      <= ost_nxt;
    oid_r      <= oid_nxt;
    ocnt_r     <= ocnt_nxt;
    olast_r    <= olast_nxt;
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = ov_r;
  assign out_tuser  = ost_r;
  assign out_tdata  = {2'b00, ocnt_r, oid_r};
  assign out_tlast  = olast_r;

`ifndef SYNTHESIS
  // The entry count never exceeds the capacity.
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(CAPACITY))
    else $error("entry count above capacity");

  // A held-back fired timer never survives into the idle state.
  a_pend_idle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE |-> !pend_v_r)
    else $error("fired timer left pending at idle");

  // The count moves by at most one entry per cycle.
  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == $past(cnt_r) || cnt_r == $past(cnt_r) + 1'b1
      || cnt_r == $past(cnt_r) - 1'b1)
    else $error("entry count jumped");

  // Heap writes stay inside the occupied region.
  a_wr_range: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> pos_r < cnt_r)
    else $error("heap write outside occupied entries");
`endif

endmodule
